// ===== src/deq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants, types and ring helpers for the bounded deque.
// ----------------------------------------------------------------------------
package deq_pkg;

	// ring size and derived widths
	localparam int DEPTH  = 64;
	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;
	localparam int CAP_W  = 7;
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int WORD_W = 32;

	// config port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_CAPACITY = 1'b0;

	// operation codes
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_REAR  = 3'd1;
	localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_REAR  = 3'd3;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [WORD_W-1:0] word_t;

	// control from the pointer logic to the store and result path
	typedef struct packed {
		logic we;
		ptr_t waddr;
		ptr_t raddr_front;
		ptr_t raddr_rear;
		logic ok;
		logic empty;
		logic full;
		logic fwd_front;
		logic fwd_rear;
	} step_t;

	// fold a sum below twice the ring size back into the ring
	function automatic ptr_t ptr_wrap(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
		return r[PTR_W-1:0];
	endfunction

endpackage

// ===== src/deq_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_mem
// Entry store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module deq_mem (
	input  logic          clk,
	input  logic          we,
	input  deq_pkg::ptr_t waddr,
	input  deq_pkg::word_t wdata,
	input  logic          re,
	input  deq_pkg::ptr_t raddr_a,
	input  deq_pkg::ptr_t raddr_b,
	output deq_pkg::word_t rdata_a,
	output deq_pkg::word_t rdata_b
);
	import deq_pkg::*;

	word_t mem [DEPTH];
	word_t rdata_a_q;
	word_t rdata_b_q;

	// write, and read old data on the same edge
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a_q <= mem[raddr_a];
			rdata_b_q <= mem[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

// ===== src/deq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Head pointer and entry count; decodes the operation into a store access.
// ----------------------------------------------------------------------------
module deq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [deq_pkg::OP_W-1:0]      operation,
	input  logic [deq_pkg::CAP_W-1:0]     capacity,
	output deq_pkg::step_t                step
);
	import deq_pkg::*;

	ptr_t head_q;
	cnt_t count_q;
	ptr_t head_n;
	cnt_t count_n;
	ptr_t head_dec;
	ptr_t head_inc;
	ptr_t tail;
	ptr_t rear_addr;
	logic [CMP_W-1:0] eff_cap;
	logic full;
	logic empty;
	logic we;
	ptr_t waddr;
	logic ok;

	// clamp capacity to the ring size
	always_comb begin
		eff_cap = (CMP_W'(capacity) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(capacity);
	end

	assign full     = CMP_W'(count_q) >= eff_cap;
	assign empty    = (count_q == '0);
	assign head_dec = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - PTR_W'(1);
	assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	assign tail     = ptr_wrap(SUM_W'(head_q) + SUM_W'(count_q));

	// decode the operation
	always_comb begin
		head_n  = head_q;
		count_n = count_q;
		we      = 1'b0;
		waddr   = tail;
		ok      = 1'b1;
		unique case (operation)
			OP_INS_FRONT: begin
				if (full) begin
					ok = 1'b0;
				end else begin
					head_n  = head_dec;
					waddr   = head_dec;
					we      = 1'b1;
					count_n = count_q + CNT_W'(1);
				end
			end
			OP_INS_REAR: begin
				if (full) begin
					ok = 1'b0;
				end else begin
					we      = 1'b1;
					count_n = count_q + CNT_W'(1);
				end
			end
			OP_DEL_FRONT: begin
				if (empty) begin
					ok = 1'b0;
				end else begin
					head_n  = head_inc;
					count_n = count_q - CNT_W'(1);
				end
			end
			OP_DEL_REAR: begin
				if (empty) begin
					ok = 1'b0;
				end else begin
					count_n = count_q - CNT_W'(1);
				end
			end
			default: begin
				ok = 1'b1;
			end
		endcase
	end

	// rear slot after the step; meaningless when the deque ends empty
	assign rear_addr = ptr_wrap(SUM_W'(head_n) + SUM_W'(count_n) - SUM_W'(1));

	// pack the store access and flags
	always_comb begin
		step.we          = we;
		step.waddr       = waddr;
		step.raddr_front = head_n;
		step.raddr_rear  = rear_addr;
		step.ok          = ok;
		step.empty       = (count_n == '0);
		step.full        = CMP_W'(count_n) >= eff_cap;
		step.fwd_front   = we && (waddr == head_n);
		step.fwd_rear    = we && (waddr == rear_addr);
	end

	// advance pointer state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_n;
			count_q <= count_n;
		end
	end

endmodule

// ===== src/bounded_double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Ring-buffer deque of signed words with a programmable capacity.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  in       | in_valid / in_ready  | operation, insert_value
//  out      | out_valid / out_ready| accepted, front_value, rear_value,
//           |                      | is_empty, is_full
//  config   | APB psel/penable     | capacity at byte address 0
//
// One beat per cycle sustained while the output is not stalled; the store read
// and the read-stage registers load at the input accept edge, then the output
// register loads from them when the read stage advances.
// Pointers update at accept, so the next beat decodes against fresh state.
// Reset clears pointers, count and capacity; the store needs no clearing.
// A stalled output holds one beat in the read stage, then drops in_ready.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [deq_pkg::ADDR_W-1:0]     paddr,
	input  logic [deq_pkg::DATA_W-1:0]     pwdata,
	output logic [deq_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [2:0]                     operation,
	input  logic signed [31:0]             insert_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           accepted,
	output logic signed [31:0]             front_value,
	output logic signed [31:0]             rear_value,
	output logic                           is_empty,
	output logic                           is_full
);
	import deq_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic             cfg_we;
	logic             accept;
	logic             adv;
	step_t            step;
	word_t            rd_front;
	word_t            rd_rear;
	word_t            front_s1;
	word_t            rear_s1;

	logic  valid_s1;
	logic  ok_s1;
	logic  empty_s1;
	logic  full_s1;
	logic  fwd_front_s1;
	logic  fwd_rear_s1;
	word_t wdata_s1;

	logic  out_valid_q;
	logic  accepted_q;
	word_t front_q;
	word_t rear_q;
	logic  empty_q;
	logic  full_q;

	// config register
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
	assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
		end else if (cfg_we) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// input handshake
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign accept   = in_valid && in_ready;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (operation),
		.capacity  (capacity_q),
		.step      (step)
	);

	deq_mem u_mem (
		.clk     (clk),
		.we      (accept && step.we),
		.waddr   (step.waddr),
		.wdata   (insert_value),
		.re      (accept),
		.raddr_a (step.raddr_front),
		.raddr_b (step.raddr_rear),
		.rdata_a (rd_front),
		.rdata_b (rd_rear)
	);

	// read stage: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// read stage: payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1        <= step.ok;
			empty_s1     <= step.empty;
			full_s1      <= step.full;
			fwd_front_s1 <= step.fwd_front;
			fwd_rear_s1  <= step.fwd_rear;
			wdata_s1     <= insert_value;
		end
	end

	// forward the word written on the same edge as the read; all ones when empty
	assign front_s1 = empty_s1 ? '1 : (fwd_front_s1 ? wdata_s1 : rd_front);
	assign rear_s1  = empty_s1 ? '1 : (fwd_rear_s1 ? wdata_s1 : rd_rear);

	// output register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register: payload
	always_ff @(posedge clk) begin
		if (adv) begin
			accepted_q <= ok_s1;
			front_q    <= front_s1;
			rear_q     <= rear_s1;
			empty_q    <= empty_s1;
			full_q     <= full_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign accepted    = accepted_q;
	assign front_value = front_q;
	assign rear_value  = rear_q;
	assign is_empty    = empty_q;
	assign is_full     = full_q;

endmodule

// ===== src/deq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks for the bounded deque, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               accepted,
	input logic signed [31:0] front_value,
	input logic signed [31:0] rear_value,
	input logic               is_empty,
	input logic               is_full
);

	// an empty deque shows all ones at both ends
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> (front_value == -32'sd1) && (rear_value == -32'sd1))
		else $error("empty result with live end values");

	// input stalls only behind a held output beat
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with output free");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(front_value)
			&& $stable(rear_value) && $stable(accepted) && $stable(is_empty)
			&& $stable(is_full))
		else $error("output beat changed while stalled");

	// no result beat leaves without an earlier input beat
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready) || $past(in_valid, 2) || $past(out_valid)
			|| $past(in_valid))
		else $error("result beat without input");

endmodule

bind bounded_double_ended_queue deq_checker u_deq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.accepted    (accepted),
	.front_value (front_value),
	.rear_value  (rear_value),
	.is_empty    (is_empty),
	.is_full     (is_full)
);

// ===== bench/deque_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker
// Watches the request, result and register ports of the bounded deque, keeps
// its own ring-buffer copy of the deque contents and compares every result
// beat field by field against the predicted status.
// ----------------------------------------------------------------------------
module deque_checker
	import deq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	input  logic                     pready,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [OP_W-1:0]          operation,
	input  logic signed [31:0]       insert_value,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic                     accepted,
	input  logic signed [31:0]       front_value,
	input  logic signed [31:0]       rear_value,
	input  logic                     is_empty,
	input  logic                     is_full,
	output int                       mismatches,
	output int                       backlog
);

	localparam logic [ADDR_W-1:0] CAPACITY_ADDR = ADDR_W'(4 * REG_CAPACITY);
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic  accepted;
		word_t front;
		word_t rear;
		logic  empty;
		logic  full;
	} deque_status_t;

	// shadow deque: ring contents, front slot, occupancy and capacity register
	word_t               ring [DEPTH];
	ptr_t                front_slot;
	cnt_t                held;
	logic [CAP_W-1:0]    capacity_reg;
	deque_status_t       expected_status [$];

	initial mismatches = 0;

	// capacity as the deque applies it: clipped to the ring size
	function automatic logic [CMP_W-1:0] usable_capacity();
		if (CMP_W'(capacity_reg) > CMP_W'(DEPTH))
			return CMP_W'(DEPTH);
		return CMP_W'(capacity_reg);
	endfunction

	task automatic report_mismatch(input string what, input word_t got, input word_t want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
	endtask

	// apply one request to the shadow deque and build the status it returns
	task automatic advance_deque(input logic [OP_W-1:0] op, input word_t value,
			output deque_status_t res);
		logic at_limit;
		logic drained;
		at_limit = CMP_W'(held) >= usable_capacity();
		drained = (held == '0);
		res.accepted = 1'b1;
		case (op)
		OP_INS_FRONT: begin
			if (at_limit) begin
				res.accepted = 1'b0;
			end else begin
				front_slot = ptr_t'(front_slot - 1'b1);
				ring[front_slot] = value;
				held = held + 1'b1;
			end
		end
		OP_INS_REAR: begin
			if (at_limit) begin
				res.accepted = 1'b0;
			end else begin
				ring[ptr_t'(front_slot + ptr_t'(held))] = value;
				held = held + 1'b1;
			end
		end
		OP_DEL_FRONT: begin
			if (drained) begin
				res.accepted = 1'b0;
			end else begin
				front_slot = ptr_t'(front_slot + 1'b1);
				held = held - 1'b1;
			end
		end
		OP_DEL_REAR: begin
			if (drained) begin
				res.accepted = 1'b0;
			end else begin
				held = held - 1'b1;
			end
		end
		default: begin
			// no-op and spare codes leave the deque alone
		end
		endcase
		res.empty = (held == '0);
		res.full = CMP_W'(held) >= usable_capacity();
		if (res.empty) begin
			res.front = '1;
			res.rear = '1;
		end else begin
			res.front = ring[front_slot];
			res.rear = ring[ptr_t'(front_slot + ptr_t'(held - 1'b1))];
		end
	endtask

	// track register writes, predict on request beats, compare on result beats
	always @(posedge clk or negedge arst_n) begin
		deque_status_t want;
		if (!arst_n) begin
			front_slot = '0;
			held = '0;
			capacity_reg = '0;
			expected_status.delete();
			backlog <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == CAPACITY_ADDR)
				capacity_reg = pwdata[CAP_W-1:0];
			if (in_valid && in_ready) begin
				advance_deque(operation, insert_value, want);
				expected_status = {expected_status, want};
			end
			if (out_valid && out_ready) begin
				if (expected_status.size() == 0) begin
					report_mismatch("unexpected result beat", front_value, '0);
				end else begin
					want = expected_status.pop_front();
					if (accepted !== want.accepted)
						report_mismatch("accepted", word_t'(accepted), word_t'(want.accepted));
					if (front_value !== want.front)
						report_mismatch("front_value", front_value, want.front);
					if (rear_value !== want.rear)
						report_mismatch("rear_value", rear_value, want.rear);
					if (is_empty !== want.empty)
						report_mismatch("is_empty", word_t'(is_empty), word_t'(want.empty));
					if (is_full !== want.full)
						report_mismatch("is_full", word_t'(is_full), word_t'(want.full));
				end
			end
			backlog <= expected_status.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the bounded deque with directed corner requests and biased random
// request streams over a range of capacity settings, with bursty requests and
// a randomly stalling result sink; the checker beside the deque judges every
// result beat.
// ----------------------------------------------------------------------------
module tb_top;
	import deq_pkg::*;

	localparam logic [OP_W-1:0]   OP_NONE        = 3'd4;
	localparam logic [OP_W-1:0]   OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0]   OP_SPARE_LAST  = 3'd7;
	localparam logic [ADDR_W-1:0] CAPACITY_ADDR  = ADDR_W'(4 * REG_CAPACITY);
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 150;
	localparam int HOLD_AFTER  = 500;
	localparam int LONG_HOLD   = 300;

	logic                   clk;
	logic                   arst_n       = 1'b0;
	logic                   psel         = 1'b0;
	logic                   penable      = 1'b0;
	logic                   pwrite       = 1'b0;
	logic [ADDR_W-1:0]      paddr        = '0;
	logic [DATA_W-1:0]      pwdata       = '0;
	logic [DATA_W-1:0]      prdata;
	logic                   pready;
	logic                   in_valid     = 1'b0;
	logic                   in_ready;
	logic [OP_W-1:0]        operation    = OP_NONE;
	logic signed [31:0]     insert_value = '0;
	logic                   out_valid;
	logic                   out_ready    = 1'b0;
	logic                   accepted;
	logic signed [31:0]     front_value;
	logic signed [31:0]     rear_value;
	logic                   is_empty;
	logic                   is_full;
	int                     fail_total;
	int                     pending_beats;

	int items_sent = 0;
	int burst_left = 0;
	int phase_cap [PHASES] = '{127, 1, 64, 0, 100, 5, 64, 33};

	bounded_double_ended_queue dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .insert_value(insert_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.accepted(accepted), .front_value(front_value), .rear_value(rear_value),
		.is_empty(is_empty), .is_full(is_full)
	);

	deque_checker deque_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .insert_value(insert_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.accepted(accepted), .front_value(front_value), .rear_value(rear_value),
		.is_empty(is_empty), .is_full(is_full),
		.mismatches(fail_total), .backlog(pending_beats)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop in case the deque hangs
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// setup cycle, access cycle, then release the bus
	task automatic write_capacity(input int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAPACITY_ADDR;
		pwdata <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// offer one request beat, inserting a random gap between bursts
	task automatic send_request(input logic [OP_W-1:0] op, input word_t value);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
		in_valid <= 1'b1;
		operation <= op;
		insert_value <= value;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// stop offering and wait until every result beat has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_beats != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic word_t pick_value();
		case ($urandom_range(0, 7))
		0: return 32'h7FFF_FFFF;
		1: return 32'h8000_0000;
		2: return '0;
		3: return '1;
		default: return $urandom;
		endcase
	endfunction

	// insert with the given percentage, else delete, with a few no-ops mixed in
	task automatic send_random_request(input int ins_pct);
		int roll;
		logic [OP_W-1:0] op;
		roll = $urandom_range(0, 99);
		if (roll < ins_pct)
			op = $urandom_range(0, 1) ? OP_INS_REAR : OP_INS_FRONT;
		else if (roll < 95)
			op = $urandom_range(0, 1) ? OP_DEL_REAR : OP_DEL_FRONT;
		else
			op = OP_W'($urandom_range(OP_NONE, OP_SPARE_LAST));
		send_request(op, pick_value());
	endtask

	// result sink: long ready runs, random chatter, stall bursts, one long hold
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		@(posedge clk);
		forever begin
			if (!hold_done && items_sent >= HOLD_AFTER) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			case ($urandom_range(0, 3))
			0: begin
				out_ready <= 1'b1;
				repeat ($urandom_range(40, 120)) @(posedge clk);
			end
			1: begin
				repeat ($urandom_range(16, 48)) begin
					out_ready <= 1'($urandom_range(0, 1));
					@(posedge clk);
				end
			end
			default: begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			endcase
		end
	end

	// stimulus
	initial begin
		int ins_pct;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero capacity: empty and full at once, every insert and delete refused
		write_capacity(0);
		send_request(OP_INS_FRONT, 32'h0000_0005);
		send_request(OP_INS_REAR, 32'h0000_0006);
		send_request(OP_DEL_FRONT, '0);
		send_request(OP_DEL_REAR, '0);
		send_request(OP_NONE, '1);
		for (int k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++)
			send_request(OP_W'(k), $urandom);
		drain_results();

		// fill a small deque from both ends with extreme words, then overflow
		write_capacity(4);
		send_request(OP_INS_FRONT, 32'h7FFF_FFFF);
		send_request(OP_INS_REAR, 32'h8000_0000);
		send_request(OP_INS_FRONT, 32'hFFFF_FFFF);
		send_request(OP_INS_REAR, 32'h0000_0000);
		send_request(OP_INS_REAR, 32'h0000_0001);
		send_request(OP_INS_FRONT, 32'h0000_0002);
		drain_results();

		// shrink below the held count: inserts refused, deletes still work
		write_capacity(2);
		send_request(OP_INS_REAR, 32'h1234_5678);
		send_request(OP_DEL_FRONT, '0);
		send_request(OP_DEL_REAR, '0);
		send_request(OP_INS_FRONT, 32'h8765_4321);
		send_request(OP_DEL_FRONT, '0);
		send_request(OP_DEL_REAR, '0);
		send_request(OP_DEL_FRONT, '0);
		drain_results();

		// random streams; each phase opens insert-heavy to reach the capacity
		for (int p = 0; p < PHASES; p++) begin
			write_capacity(phase_cap[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 40 == 0) begin
					if (i < 80) begin
						ins_pct = 95;
					end else begin
						case ($urandom_range(0, 2))
						0: ins_pct = 10;
						1: ins_pct = 50;
						default: ins_pct = 90;
						endcase
					end
				end
				send_random_request(ins_pct);
			end
			drain_results();
		end

		repeat (8) @(posedge clk);
		if (fail_total == 0 && pending_beats == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
